### rtl/core/pcs_pkg.sv
// Package for the periodic coordinate store: command codes, sizes and types.
// No dependencies.
package pcs_pkg;
  localparam int NumParticles = 1024;
  localparam int NumDims = 3;
  localparam int CoordBits = 32;
  localparam logic [30:0] BoxReset = 31'd1048576;

  typedef enum logic [2:0] {
    CMD_SET = 3'd0, CMD_DISP = 3'd1, CMD_WRAP = 3'd2, CMD_SAVE = 3'd3,
    CMD_RESTORE = 3'd4, CMD_PAIR = 3'd5, CMD_PROBE = 3'd6, CMD_NOP = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  ia;
    logic [9:0]  ib;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        use_box;
  } req_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_SUM} state_t;
endpackage

### rtl/core/pcs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pcs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/core/pcs_front.sv
// Front end: accepts requests into a two-entry queue.
// Depends on pcs_pkg.
module pcs_front import pcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic q_valid,
  output req_t q_req,
  input  logic q_pop
);
  req_t       buf_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = cnt_r == 2'd2;
  assign push = in_valid && !in_stall;
  assign q_valid = cnt_r != 2'd0;
  assign q_req = buf_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push) buf_r[wp_r] <= in_req;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
endmodule

### rtl/core/pcs_back.sv
// Back end: coordinate memories, update and squared distance datapath.
// Depends on pcs_pkg and pcs_ram.
module pcs_back import pcs_pkg::*; #(
  parameter int NumPart = NumParticles,
  parameter int NumDim = NumDims,
  parameter int CBits = CoordBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] box,
  input  logic        q_valid,
  input  req_t        q_req,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_dist_squared,
  output logic        out_saturated
);
  localparam int AW = $clog2(NumPart);
  localparam logic signed [34:0] CHi = 35'sd1 <<< (CBits - 1);

  state_t st_r, st_nxt;
  req_t   r_r;
  logic signed [31:0] bak_r [NumDim];
  logic [63:0] sq_r [NumDim];
  logic        big_r [NumDim];
  logic        ova_r, ovb_r, ld, go_sq;
  logic [AW-1:0] addr_a, addr_b;
  logic [CBits-1:0] rda [NumDim];
  logic [CBits-1:0] rdb [NumDim];
  logic [CBits-1:0] wd [NumDim];
  logic        we;
  logic        is_dist;
  logic        ovb_use;

  assign is_dist = r_r.cmd == CMD_PAIR || r_r.cmd == CMD_PROBE;
  assign addr_a = st_r == ST_IDLE ? AW'(q_req.ia) : AW'(r_r.ia);
  assign addr_b = st_r == ST_IDLE ? AW'(q_req.ib) :
                  (st_r == ST_EXEC ? AW'(r_r.ia) : AW'(r_r.ib));
  assign ld = q_pop;
  assign ovb_use = ovb_r;

  function automatic logic signed [34:0] vcomp(input req_t r, input int d);
    case (d)
      0: vcomp = 35'(signed'(r.vx));
      1: vcomp = 35'(signed'(r.vy));
      default: vcomp = 35'(signed'(r.vz));
    endcase
  endfunction

  function automatic logic [CBits-1:0] clampc(input logic signed [34:0] v);
    if (v > CHi - 35'sd1) clampc = CBits'(CHi - 35'sd1);
    else if (v < -CHi) clampc = CBits'(-CHi);
    else clampc = CBits'(v);
  endfunction

  for (genvar d = 0; d < NumDim; d++) begin : g_dim
    logic signed [34:0] a, b, s, df, dfm, bx, mag;
    pcs_ram #(.Width(CBits), .Depth(NumPart)) u_a (
      .clk(clk), .we(we), .addr(addr_a),
      .wdata(wd[d]), .rdata(rda[d]));
    pcs_ram #(.Width(CBits), .Depth(NumPart)) u_b (
      .clk(clk), .we(we), .addr(addr_b),
      .wdata(wd[d]), .rdata(rdb[d]));
    always_comb begin
      bx = 35'(box);
      a = ova_r ? 35'sd0 : 35'(signed'(rda[d]));
      b = r_r.cmd == CMD_PROBE ? vcomp(r_r, d)
          : (ovb_use ? 35'sd0 : 35'(signed'(rdb[d])));
      s = a + vcomp(r_r, d);
      if (r_r.cmd == CMD_WRAP) begin
        if (s < 0) s = s + bx;
        if (s > bx) s = s - bx;
      end
      case (r_r.cmd)
        CMD_SET: wd[d] = clampc(vcomp(r_r, d));
        CMD_RESTORE: wd[d] = clampc(35'(bak_r[d]));
        default: wd[d] = clampc(s);
      endcase
      df = a - b;
      dfm = df;
      if (r_r.use_box) begin
        if ((df <<< 1) > bx) dfm = df - bx;
        else if ((df <<< 1) < -bx) dfm = df + bx;
      end
      mag = dfm < 0 ? -dfm : dfm;
    end
    always_ff @(posedge clk) begin
      if (st_r == ST_EXEC) begin
        big_r[d] <= mag > 35'sh0FFFFFFFF;
        sq_r[d] <= 64'(mag[31:0]) * 64'(mag[31:0]);
        if (r_r.cmd == CMD_SAVE) bak_r[d] <= 32'(a);
      end
    end
  end

  assign we = st_r == ST_EXEC && !ova_r &&
    (r_r.cmd == CMD_SET || r_r.cmd == CMD_DISP || r_r.cmd == CMD_WRAP ||
     r_r.cmd == CMD_RESTORE);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_EXEC;
      ST_EXEC: st_nxt = is_dist ? ST_SUM : ST_IDLE;
      ST_SUM: if (!out_valid || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = st_r == ST_IDLE && q_valid;
    go_sq = st_r == ST_SUM && (!out_valid || !out_stall);
  end

  logic [64:0] acc;
  logic        sat;
  logic        ov_r;
  always_comb begin
    acc = 65'd0;
    sat = 1'b0;
    for (int d = 0; d < NumDim; d++) begin
      if (big_r[d]) sat = 1'b1;
      else acc = acc + 65'(sq_r[d]);
      if (acc[64]) sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (go_sq) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (ld) begin
      r_r <= q_req;
      ova_r <= 32'(q_req.ia) >= NumPart;
      ovb_r <= 32'(q_req.ib) >= NumPart;
    end
    if (go_sq) begin
      out_dist_squared <= sat ? '1 : acc[63:0];
      out_saturated <= sat;
    end
  end
  assign out_valid = ov_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    we |-> st_r == ST_EXEC)
    else $error("write outside execute");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_IDLE)
    else $error("pop while busy");
endmodule

### rtl/core/periodic_coordinate_store.sv
// Periodic coordinate store top level: front queue, back datapath, box register.
// Update commands pass through the back end's read and execute states; distance
// commands add a sum state, held while the output stalls, that registers the result.
// The back end finishes one item, including its memory read and write, before it takes the next.
// Synchronous active-low reset clears control state and loads box length 16.0.
module periodic_coordinate_store import pcs_pkg::*; #(
  parameter int NumPart = NumParticles,
  parameter int NumDim = NumDims,
  parameter int CBits = CoordBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [9:0]  in_index_a,
  input  logic [9:0]  in_index_b,
  input  logic [31:0] in_vec_x,
  input  logic [31:0] in_vec_y,
  input  logic [31:0] in_vec_z,
  input  logic        in_use_box,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_dist_squared,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_box_length
);
  logic [30:0] box_r;
  req_t in_req, q_req;
  logic q_valid, q_pop;

  assign cfg_ready = 1'b1;
  assign in_req = '{cmd: cmd_t'(in_command), ia: in_index_a, ib: in_index_b,
                    vx: in_vec_x, vy: in_vec_y, vz: in_vec_z, use_box: in_use_box};

  always_ff @(posedge clk) begin
    if (!rst_n) box_r <= BoxReset;
    else if (cfg_valid) box_r <= cfg_box_length;
  end

  pcs_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop));

  pcs_back #(.NumPart(NumPart), .NumDim(NumDim), .CBits(CBits)) u_back (
    .clk(clk), .rst_n(rst_n), .box(box_r), .q_valid(q_valid), .q_req(q_req),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_dist_squared(out_dist_squared), .out_saturated(out_saturated));
endmodule

### dv/periodic_coordinate_store_test.sv
// Self-checking testbench for the periodic coordinate store: drives random and directed
// commands, predicts squared distances with its own model, and checks every result.
// Depends on pcs_pkg and the periodic_coordinate_store RTL.
module periodic_coordinate_store_test;
  import pcs_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  ia;
    logic [9:0]  ib;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        use_box;
  } request_t;

  typedef struct packed {
    logic [63:0] dsq;
    logic        sat;
  } distance_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_accepted = 1'b0;
  logic [2:0]  in_command = '0;
  logic [9:0]  in_index_a = '0;
  logic [9:0]  in_index_b = '0;
  logic [31:0] in_vec_x = '0;
  logic [31:0] in_vec_y = '0;
  logic [31:0] in_vec_z = '0;
  logic        in_use_box = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_dist_squared;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_box_length = '0;

  periodic_coordinate_store DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_index_a, .in_index_b,
    .in_vec_x, .in_vec_y, .in_vec_z, .in_use_box, .out_valid, .out_stall,
    .out_dist_squared, .out_saturated, .cfg_valid, .cfg_ready, .cfg_box_length
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t  pending_requests[$];
  distance_t expected_distances[$];
  logic signed [31:0] model_coords[NumDims][NumParticles];
  logic signed [31:0] model_backup[NumDims];
  bit          model_written[NumParticles];
  bit          backup_valid;
  logic [30:0] model_box;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatch_count;
  int          cycle_count;
  int          accepted_count;

  function automatic logic signed [63:0] clamp_coord(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] stored_coord(logic [9:0] idx, int d);
    if (idx >= NumParticles) return '0;
    return model_coords[d][idx];
  endfunction

  task automatic predict_request(request_t r);
    logic signed [63:0] vec[3];
    logic signed [63:0] s;
    logic signed [63:0] diff;
    logic signed [63:0] b;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [64:0] sum;
    bit sat;
    distance_t res;
    vec[0] = $signed(r.vx);
    vec[1] = $signed(r.vy);
    vec[2] = $signed(r.vz);
    b = {33'd0, model_box};
    case (r.cmd)
      CMD_SET, CMD_DISP, CMD_WRAP, CMD_RESTORE: begin
        for (int d = 0; d < NumDims; d++) begin
          if (r.cmd == CMD_SET) s = vec[d];
          else if (r.cmd == CMD_RESTORE) s = model_backup[d];
          else s = stored_coord(r.ia, d) + vec[d];
          if (r.cmd == CMD_WRAP) begin
            if (s < 0) s = s + b;
            if (s > b) s = s - b;
          end
          if (r.ia < NumParticles) model_coords[d][r.ia] = 32'(clamp_coord(s));
        end
        if (r.ia < NumParticles) model_written[r.ia] = 1'b1;
      end
      CMD_SAVE: begin
        for (int d = 0; d < NumDims; d++) model_backup[d] = 32'(stored_coord(r.ia, d));
        backup_valid = 1'b1;
      end
      CMD_PAIR, CMD_PROBE: begin
        sum = '0;
        sat = 1'b0;
        for (int d = 0; d < NumDims; d++) begin
          diff = stored_coord(r.ia, d) -
                 ((r.cmd == CMD_PAIR) ? stored_coord(r.ib, d) : vec[d]);
          if (r.use_box) begin
            if (2 * diff > b) diff = diff - b;
            else if (2 * diff < -b) diff = diff + b;
          end
          mag = (diff < 0) ? -diff : diff;
          if (mag > 64'hFFFF_FFFF) begin
            sat = 1'b1;
          end else begin
            sq = mag * mag;
            sum = sum + 65'(sq);
            if (sum[64]) sat = 1'b1;
            sum[64] = 1'b0;
          end
        end
        res.dsq = sat ? '1 : sum[63:0];
        res.sat = sat;
        expected_distances.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Reads of never-written entries are avoided by redirecting them to a written one.
  function automatic logic [9:0] known_index(logic [9:0] idx);
    if (idx >= NumParticles || model_written[idx]) return idx;
    return 10'd0;
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.cmd = cmd_t'($urandom_range(0, 7));
    r.ia = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    r.ib = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    r.vx = random_coord();
    r.vy = random_coord();
    r.vz = random_coord();
    r.use_box = 1'($urandom);
    return r;
  endfunction

  // Predictions are made when items are queued: the block applies them in order.
  task automatic queue_request(request_t r);
    if (r.cmd != CMD_SET && r.cmd != CMD_NOP) r.ia = known_index(r.ia);
    if (r.cmd == CMD_PAIR) r.ib = known_index(r.ib);
    if (r.cmd == CMD_RESTORE && !backup_valid) r.cmd = CMD_SET;
    predict_request(r);
    pending_requests.push_back(r);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_command <= pending_requests[0].cmd;
        in_index_a <= pending_requests[0].ia;
        in_index_b <= pending_requests[0].ib;
        in_vec_x <= pending_requests[0].vx;
        in_vec_y <= pending_requests[0].vy;
        in_vec_z <= pending_requests[0].vz;
        in_use_box <= pending_requests[0].use_box;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) accepted_count <= accepted_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_distances.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("Unexpected result %h", out_dist_squared);
      end else begin
        if (out_dist_squared !== expected_distances[0].dsq ||
            out_saturated !== expected_distances[0].sat) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("Mismatch: expected %h/%b, got %h/%b", expected_distances[0].dsq,
                     expected_distances[0].sat, out_dist_squared, out_saturated);
        end
        void'(expected_distances.pop_front());
      end
    end
    if (cycle_count > 2000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || expected_distances.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_box(logic [30:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_box_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    model_box = value;
  endtask

  task automatic directed_requests();
    request_t r;
    r = '0;
    r.cmd = CMD_SET; r.ia = 10'd0; queue_request(r);
    r.ia = 10'd1; r.vx = 32'h7FFF_FFFF; r.vy = 32'h8000_0000; r.vz = 32'h0001_0000;
    queue_request(r);
    r.ia = 10'd1023; r.vx = 32'h8000_0000; r.vy = 32'h7FFF_FFFF; r.vz = 32'hFFFF_0000;
    queue_request(r);
    r.cmd = CMD_PAIR; r.ia = 10'd1; r.ib = 10'd1023; r.use_box = 1'b0; queue_request(r);
    r.use_box = 1'b1; queue_request(r);
    r.cmd = CMD_PROBE; r.ia = 10'd0; r.vx = 32'h0008_0001; r.vy = 32'hFFF7_FFFF;
    r.vz = 32'h0008_0000; queue_request(r);
    r.use_box = 1'b0; queue_request(r);
    r.cmd = CMD_DISP; r.ia = 10'd1; r.vx = 32'h7FFF_FFFF; r.vy = 32'h8000_0000;
    queue_request(r);
    r.cmd = CMD_WRAP; r.ia = 10'd0; r.vx = 32'hFFFF_0000; r.vy = 32'h0011_0000;
    r.vz = 32'h0010_0000; queue_request(r);
    r.cmd = CMD_SAVE; r.ia = 10'd1; queue_request(r);
    r.cmd = CMD_RESTORE; r.ia = 10'd0; queue_request(r);
    r.cmd = CMD_SAVE; r.ia = 10'd1023; queue_request(r);
    r.cmd = CMD_RESTORE; r.ia = 10'd2; queue_request(r);
    r.cmd = CMD_NOP; r.ia = 10'h3FF; queue_request(r);
    r.cmd = CMD_PAIR; r.ia = 10'd0; r.ib = 10'd2; r.use_box = 1'b1; queue_request(r);
    r.cmd = CMD_PROBE; r.ia = 10'd1; r.vx = 32'h8000_0000; r.vy = 32'h7FFF_FFFF;
    r.vz = 32'h8000_0000; queue_request(r);
  endtask

  initial begin
    logic [30:0] boxes[4];
    boxes = '{31'h7FFF_FFFF, 31'd0, 31'h0004_0000, 31'h0010_0000};
    model_box = BoxReset;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    accepted_count = 0;
    backup_valid = 1'b0;
    for (int i = 0; i < NumParticles; i++) model_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed_requests();
    wait_idle();
    for (int phase = 0; phase < 4; phase++) begin
      write_box(boxes[phase]);
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int n = 0; n < 375; n++) queue_request(random_request());
      wait_idle();
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_distances.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
